@@ rtl/sealed_region_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// Sealed region table - assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEALED_REGION_TABLE_TOP_DEFINES_SVH
`define SEALED_REGION_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sealed region table check failed");

// Next-cycle implication, disabled during reset.
`define SRT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("sealed region table check failed");

`endif

@@ rtl/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sealed region table - package
// Sizes, operation and result codes, and controller/datapath interface types.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int PAGE_BITS   = 12;
  localparam int DESC_SHIFT  = 5;   // 32-byte descriptor stride
  localparam int ADDR_W      = 64;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int OFF_W       = ADDR_W - PAGE_BITS;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] CLS_NONE    = 2'd0;
  localparam logic [1:0] CLS_NO_DESC = 2'd1;
  localparam logic [1:0] CLS_DESC    = 2'd2;

  localparam logic [1:0] KIND_INIT   = 2'd0;
  localparam logic [1:0] KIND_BSS    = 2'd2;

  typedef struct packed {
    logic load;        // latch request fields
    logic add;         // append entry if not full, and report
    logic scan_init;   // read entry 0
    logic scan_step;   // read next entry, advance eval pointer
    logic take_hit;    // capture lookup hit entry
    logic res_edit;    // apply delete/update at eval entry and report
    logic res_miss;    // report no match
    logic res_lookup;  // report lookup hit
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       last;
  } stat_t;

endpackage

@@ rtl/srt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sealed region table - controller
// Sequences add, table scan and lookup result calculation.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     opcode,
  input  srt_pkg::stat_t stat,
  output srt_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (opcode == srt_pkg::OP_ADD) ? S_ADD : S_PRIME;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_IDLE;
      end
      S_PRIME: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (stat.hit) begin
          if (stat.op == srt_pkg::OP_LOOKUP) begin
            cmd.take_hit = 1'b1;
            state_next   = S_CALC;
          end else begin
            cmd.res_edit = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (stat.last) begin
          cmd.res_miss = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CALC: begin
        cmd.res_lookup = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/srt_datapath.sv @@
// ----------------------------------------------------------------------------
// Sealed region table - datapath
// Region memories, valid bits, fill count, entry compare and result registers.
// ----------------------------------------------------------------------------
module srt_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  srt_pkg::cmd_t              cmd,
  input  logic [1:0]                 opcode,
  input  logic [srt_pkg::ADDR_W-1:0] start_addr,
  input  logic [srt_pkg::ADDR_W-1:0] end_addr,
  input  logic [srt_pkg::ADDR_W-1:0] descriptor_base,
  input  logic [srt_pkg::ADDR_W-1:0] new_end_addr,
  input  logic [1:0]                 region_kind,
  output srt_pkg::stat_t             stat,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [1:0]                 seal_class,
  output logic [srt_pkg::ADDR_W-1:0] descriptor_addr,
  output logic [1:0]                 found_kind
);

  // region memories
  logic [srt_pkg::ADDR_W-1:0] start_mem [srt_pkg::MAX_REGIONS];
  logic [srt_pkg::ADDR_W-1:0] end_mem   [srt_pkg::MAX_REGIONS];
  logic [srt_pkg::ADDR_W-1:0] desc_mem  [srt_pkg::MAX_REGIONS];
  logic [1:0]                 kind_mem  [srt_pkg::MAX_REGIONS];

  logic [srt_pkg::MAX_REGIONS-1:0] valid;
  logic [srt_pkg::CNT_W-1:0]       count;

  // latched request
  logic [1:0]                 req_op;
  logic [srt_pkg::ADDR_W-1:0] req_start;
  logic [srt_pkg::ADDR_W-1:0] req_end;
  logic [srt_pkg::ADDR_W-1:0] req_base;
  logic [srt_pkg::ADDR_W-1:0] req_new_end;
  logic [1:0]                 req_kind;

  // scan pointers and registered read data
  logic [srt_pkg::IDX_W-1:0]  rd_idx;
  logic [srt_pkg::IDX_W-1:0]  eval_idx;
  logic [srt_pkg::ADDR_W-1:0] ent_start;
  logic [srt_pkg::ADDR_W-1:0] ent_end;
  logic [srt_pkg::ADDR_W-1:0] ent_desc;
  logic [1:0]                 ent_kind;

  // captured lookup hit
  logic [srt_pkg::OFF_W-1:0]  hit_off;
  logic [srt_pkg::ADDR_W-1:0] hit_desc;
  logic [1:0]                 hit_kind;

  logic [srt_pkg::IDX_W-1:0]  rd_addr;
  logic [srt_pkg::IDX_W-1:0]  add_idx;
  logic                       full;
  logic                       rd_en;
  logic                       entry_valid;
  logic                       exact;
  logic                       covers;
  logic [srt_pkg::ADDR_W-1:0] page;
  logic [srt_pkg::ADDR_W-1:0] page_diff;
  logic [1:0]                 store_kind;
  logic                       no_desc;
  logic [srt_pkg::ADDR_W-1:0] desc_sum;

  assign rd_en      = cmd.scan_init | cmd.scan_step;
  assign rd_addr    = cmd.scan_init ? '0 : rd_idx;
  assign add_idx    = count[srt_pkg::IDX_W-1:0];
  assign full       = (count == srt_pkg::CNT_W'(srt_pkg::MAX_REGIONS));
  assign store_kind = (req_kind > srt_pkg::KIND_BSS) ? srt_pkg::KIND_BSS : req_kind;

  assign entry_valid = valid[eval_idx];
  assign exact  = entry_valid && (ent_start == req_start) && (ent_end == req_end);
  assign covers = entry_valid && (req_start >= ent_start) && (req_start <= ent_end);

  assign page      = {req_start[srt_pkg::ADDR_W-1:srt_pkg::PAGE_BITS],
                      {srt_pkg::PAGE_BITS{1'b0}}};
  assign page_diff = page - ent_start;

  assign no_desc  = (hit_desc == '1);
  assign desc_sum = hit_desc + {{(srt_pkg::PAGE_BITS - srt_pkg::DESC_SHIFT){1'b0}},
                                hit_off, {srt_pkg::DESC_SHIFT{1'b0}}};

  assign stat.op   = req_op;
  assign stat.hit  = (req_op == srt_pkg::OP_LOOKUP) ? covers : exact;
  assign stat.last = (eval_idx == srt_pkg::IDX_W'(srt_pkg::MAX_REGIONS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op      <= opcode;
      req_start   <= start_addr;
      req_end     <= end_addr;
      req_base    <= descriptor_base;
      req_new_end <= new_end_addr;
      req_kind    <= region_kind;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.add && !full) begin
      start_mem[add_idx] <= req_start;
      end_mem[add_idx]   <= req_end;
      desc_mem[add_idx]  <= req_base;
      kind_mem[add_idx]  <= store_kind;
    end else if (cmd.res_edit && (req_op == srt_pkg::OP_UPDATE)) begin
      end_mem[eval_idx] <= req_new_end;
    end
    if (rd_en) begin
      ent_start <= start_mem[rd_addr];
      ent_end   <= end_mem[rd_addr];
      ent_desc  <= desc_mem[rd_addr];
      ent_kind  <= kind_mem[rd_addr];
    end
  end

  // scan pointers hold at the last entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      eval_idx <= rd_addr;
      rd_idx   <= (rd_addr == srt_pkg::IDX_W'(srt_pkg::MAX_REGIONS - 1)) ?
                  rd_addr : rd_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      hit_off  <= page_diff[srt_pkg::ADDR_W-1:srt_pkg::PAGE_BITS];
      hit_desc <= ent_desc;
      hit_kind <= ent_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.add | cmd.res_edit | cmd.res_miss | cmd.res_lookup;
      if (cmd.add && !full) begin
        valid[add_idx] <= 1'b1;
        count          <= count + 1'b1;
      end
      if (cmd.res_edit && (req_op == srt_pkg::OP_DELETE)) begin
        valid[eval_idx] <= 1'b0;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      status          <= full ? srt_pkg::ST_FULL : srt_pkg::ST_OK;
      seal_class      <= srt_pkg::CLS_NONE;
      descriptor_addr <= '0;
      found_kind      <= srt_pkg::KIND_INIT;
    end else if (cmd.res_edit) begin
      status          <= srt_pkg::ST_OK;
      seal_class      <= srt_pkg::CLS_NONE;
      descriptor_addr <= '0;
      found_kind      <= srt_pkg::KIND_INIT;
    end else if (cmd.res_miss) begin
      status          <= (req_op == srt_pkg::OP_LOOKUP) ? srt_pkg::ST_OK
                                                        : srt_pkg::ST_NOT_FOUND;
      seal_class      <= srt_pkg::CLS_NONE;
      descriptor_addr <= '0;
      found_kind      <= srt_pkg::KIND_INIT;
    end else if (cmd.res_lookup) begin
      status          <= srt_pkg::ST_OK;
      seal_class      <= no_desc ? srt_pkg::CLS_NO_DESC : srt_pkg::CLS_DESC;
      descriptor_addr <= no_desc ? '0 : desc_sum;
      found_kind      <= hit_kind;
    end
  end

endmodule

@@ rtl/sealed_region_table_top.sv @@
// Sequence: an add goes from accept through the add state to done; delete, update and
// lookup prime the read of entry 0 and scan the table, and a lookup hit adds a calc state.
// A new transaction is accepted in the cycle its predecessor's result is shown; the scan
// steps one entry per cycle through the table read port until a hit or the last entry.
// Synchronous active-high reset clears the valid bits and the fill count at once.
// Results are one-cycle strobes on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Sealed region table - top level
// Table of protected address regions with add, delete, update end and lookup.
// ----------------------------------------------------------------------------
`include "sealed_region_table_top_defines.svh"

module sealed_region_table_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [srt_pkg::ADDR_W-1:0] start_addr,
  input  logic [srt_pkg::ADDR_W-1:0] end_addr,
  input  logic [srt_pkg::ADDR_W-1:0] descriptor_base,
  input  logic [srt_pkg::ADDR_W-1:0] new_end_addr,
  input  logic [1:0]                 region_kind,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [1:0]                 seal_class,
  output logic [srt_pkg::ADDR_W-1:0] descriptor_addr,
  output logic [1:0]                 found_kind
);

  srt_pkg::cmd_t  cmd;
  srt_pkg::stat_t stat;

  srt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  srt_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .opcode          (opcode),
    .start_addr      (start_addr),
    .end_addr        (end_addr),
    .descriptor_base (descriptor_base),
    .new_end_addr    (new_end_addr),
    .region_kind     (region_kind),
    .stat            (stat),
    .done            (done),
    .status          (status),
    .seal_class      (seal_class),
    .descriptor_addr (descriptor_addr),
    .found_kind      (found_kind)
  );

  // every result command returns the controller to idle
  `SRT_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `SRT_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `SRT_ASSERT_IMP(a_daddr_zero, clk, rst, done && (seal_class != srt_pkg::CLS_DESC),
                  descriptor_addr == '0)
  `SRT_ASSERT_IMP(a_err_no_seal, clk, rst, done && (status != srt_pkg::ST_OK),
                  (seal_class == srt_pkg::CLS_NONE) && (found_kind == srt_pkg::KIND_INIT))

endmodule
